FILE: rtl/core/sgi_pkg.sv
// Shared constants for the segment intersection pipeline.
package sgi_pkg;

   localparam int COORD_W_DEF = 16;
   localparam int T_FRAC_DEF  = 16;
   localparam int OUT_W       = 32;
   localparam int N_COORDS    = 8;

   // Order of the coordinates inside the request payload.
   localparam int A_START_X = 0;
   localparam int A_START_Y = 1;
   localparam int A_END_X   = 2;
   localparam int A_END_Y   = 3;
   localparam int B_START_X = 4;
   localparam int B_START_Y = 5;
   localparam int B_END_X   = 6;
   localparam int B_END_Y   = 7;

endpackage

FILE: rtl/core/sgi_front.sv
// Front stages: direction vectors, cross products, denominator and dividend setup.
module sgi_front #(
   parameter int COORD_W = sgi_pkg::COORD_W_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  logic                                       in_valid,
   input  logic [sgi_pkg::N_COORDS*COORD_W-1:0]       coords,
   output logic                                       out_valid,
   output logic                                       nz,
   output logic                                       ok1,
   output logic                                       ok2,
   output logic [2*COORD_W+2:0]                       n1u,
   output logic [2*COORD_W+2:0]                       n2u,
   output logic [2*COORD_W+2:0]                       den,
   output logic signed [COORD_W-1:0]                  x1,
   output logic signed [COORD_W-1:0]                  y1,
   output logic signed [COORD_W:0]                    dx1,
   output logic signed [COORD_W:0]                    dy1
);

   localparam int DW = COORD_W + 1;
   localparam int PW = 2 * COORD_W + 2;
   localparam int NW = 2 * COORD_W + 3;
   localparam int EW = NW + 1;

   logic signed [COORD_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

   assign ax0 = signed'(coords[sgi_pkg::A_START_X*COORD_W +: COORD_W]);
   assign ay0 = signed'(coords[sgi_pkg::A_START_Y*COORD_W +: COORD_W]);
   assign ax1 = signed'(coords[sgi_pkg::A_END_X*COORD_W +: COORD_W]);
   assign ay1 = signed'(coords[sgi_pkg::A_END_Y*COORD_W +: COORD_W]);
   assign bx0 = signed'(coords[sgi_pkg::B_START_X*COORD_W +: COORD_W]);
   assign by0 = signed'(coords[sgi_pkg::B_START_Y*COORD_W +: COORD_W]);
   assign bx1 = signed'(coords[sgi_pkg::B_END_X*COORD_W +: COORD_W]);
   assign by1 = signed'(coords[sgi_pkg::B_END_Y*COORD_W +: COORD_W]);

   // Stage 1: differences.
   logic [3:0] v_ff;
   logic signed [COORD_W-1:0] x1_s1_ff, y1_s1_ff, x1_s2_ff, y1_s2_ff, x1_s3_ff, y1_s3_ff;
   logic signed [COORD_W-1:0] x1_s4_ff, y1_s4_ff;
   logic signed [DW-1:0] dx1_s1_ff, dy1_s1_ff, dx2_ff, dy2_ff, ex_ff, ey_ff;
   logic signed [DW-1:0] dx1_s2_ff, dy1_s2_ff, dx1_s3_ff, dy1_s3_ff, dx1_s4_ff, dy1_s4_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [NW-1:0] den_ff, n1_ff, n2_ff;
   logic nz_ff, ok1_ff, ok2_ff;
   logic [NW-1:0] n1u_ff, n2u_ff, dp_ff;

   logic [3:0] v_in;
   assign v_in = {v_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_s1_ff  <= ax0;
         y1_s1_ff  <= ay0;
         dx1_s1_ff <= DW'(ax1) - DW'(ax0);
         dy1_s1_ff <= DW'(ay1) - DW'(ay0);
         dx2_ff    <= DW'(bx1) - DW'(bx0);
         dy2_ff    <= DW'(by1) - DW'(by0);
         ex_ff     <= DW'(bx0) - DW'(ax0);
         ey_ff     <= DW'(by0) - DW'(ay0);
      end
   end

   // Stage 2: the six cross-product terms.
   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff     <= PW'(dx2_ff) * PW'(dy1_s1_ff);
         pb_ff     <= PW'(dx1_s1_ff) * PW'(dy2_ff);
         pc_ff     <= PW'(dx2_ff) * PW'(ey_ff);
         pd_ff     <= PW'(dy2_ff) * PW'(ex_ff);
         pe_ff     <= PW'(dx1_s1_ff) * PW'(ey_ff);
         pf_ff     <= PW'(dy1_s1_ff) * PW'(ex_ff);
         x1_s2_ff  <= x1_s1_ff;
         y1_s2_ff  <= y1_s1_ff;
         dx1_s2_ff <= dx1_s1_ff;
         dy1_s2_ff <= dy1_s1_ff;
      end
   end

   // Stage 3: denominator and both numerators.
   always_ff @(posedge clock) begin
      if (en) begin
         den_ff    <= NW'(pa_ff) - NW'(pb_ff);
         n1_ff     <= NW'(pc_ff) - NW'(pd_ff);
         n2_ff     <= NW'(pe_ff) - NW'(pf_ff);
         x1_s3_ff  <= x1_s2_ff;
         y1_s3_ff  <= y1_s2_ff;
         dx1_s3_ff <= dx1_s2_ff;
         dy1_s3_ff <= dy1_s2_ff;
      end
   end

   // Stage 4: make the denominator positive, range check, and bias each
   // numerator by one denominator so the divider sees a value in [0, 3*den].
   logic signed [NW-1:0] dp_in, m1, m2;
   logic signed [EW-1:0] dpe, m1e, m2e, s1e, s2e;
   logic ok1_in, ok2_in;

   always_comb begin
      dp_in  = den_ff[NW-1] ? -den_ff : den_ff;
      m1     = den_ff[NW-1] ? -n1_ff : n1_ff;
      m2     = den_ff[NW-1] ? -n2_ff : n2_ff;
      dpe    = EW'(dp_in);
      m1e    = EW'(m1);
      m2e    = EW'(m2);
      ok1_in = (m1e >= -dpe) && (m1e <= (dpe <<< 1));
      ok2_in = (m2e >= -dpe) && (m2e <= (dpe <<< 1));
      s1e    = m1e + dpe;
      s2e    = m2e + dpe;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nz_ff     <= (den_ff != '0);
         ok1_ff    <= ok1_in;
         ok2_ff    <= ok2_in;
         n1u_ff    <= s1e[NW-1:0];
         n2u_ff    <= s2e[NW-1:0];
         dp_ff     <= dp_in;
         x1_s4_ff  <= x1_s3_ff;
         y1_s4_ff  <= y1_s3_ff;
         dx1_s4_ff <= dx1_s3_ff;
         dy1_s4_ff <= dy1_s3_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign nz        = nz_ff;
   assign ok1       = ok1_ff;
   assign ok2       = ok2_ff;
   assign n1u       = n1u_ff;
   assign n2u       = n2u_ff;
   assign den       = dp_ff;
   assign x1        = x1_s4_ff;
   assign y1        = y1_s4_ff;
   assign dx1       = dx1_s4_ff;
   assign dy1       = dy1_s4_ff;

endmodule

FILE: rtl/core/sgi_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
module sgi_div #(
   parameter int UW     = 2 * sgi_pkg::COORD_W_DEF + 3,
   parameter int NS     = sgi_pkg::T_FRAC_DEF + 3,
   parameter int SIDE_W = 3 + 4 * sgi_pkg::COORD_W_DEF + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [UW-1:0]     n1,
   input  logic [UW-1:0]     n2,
   input  logic [UW-1:0]     den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [NS-1:0]     q1,
   output logic [NS-1:0]     q2,
   output logic [SIDE_W-1:0] side_out
);

   logic              v_ff    [1:NS];
   logic [UW-1:0]     r1_ff   [1:NS];
   logic [UW-1:0]     r2_ff   [1:NS];
   logic [UW-1:0]     d_ff    [1:NS];
   logic [NS-1:0]     q1_ff   [1:NS];
   logic [NS-1:0]     q2_ff   [1:NS];
   logic [SIDE_W-1:0] side_ff [1:NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic              src_v;
      logic [UW-1:0]     src_r1, src_r2, src_d;
      logic [NS-1:0]     src_q1, src_q2;
      logic [SIDE_W-1:0] src_side;
      logic [UW:0]       a1, a2, b, diff1, diff2;
      logic              bit1, bit2;

      if (s == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_r1   = n1;
         assign src_r2   = n2;
         assign src_d    = den;
         assign src_q1   = '0;
         assign src_q2   = '0;
         assign src_side = side_in;
      end else begin : g_next
         assign src_v    = v_ff[s];
         assign src_r1   = r1_ff[s];
         assign src_r2   = r2_ff[s];
         assign src_d    = d_ff[s];
         assign src_q1   = q1_ff[s];
         assign src_q2   = q2_ff[s];
         assign src_side = side_ff[s];
      end

      // The first two stages find the integer part (0..3) without shifting;
      // the rest produce fraction bits.
      if (s == 0) begin : g_int_hi
         assign a1 = {1'b0, src_r1};
         assign a2 = {1'b0, src_r2};
         assign b  = {src_d, 1'b0};
      end else if (s == 1) begin : g_int_lo
         assign a1 = {1'b0, src_r1};
         assign a2 = {1'b0, src_r2};
         assign b  = {1'b0, src_d};
      end else begin : g_frac
         assign a1 = {src_r1, 1'b0};
         assign a2 = {src_r2, 1'b0};
         assign b  = {1'b0, src_d};
      end

      assign bit1  = (a1 >= b);
      assign bit2  = (a2 >= b);
      assign diff1 = bit1 ? (a1 - b) : a1;
      assign diff2 = bit2 ? (a2 - b) : a2;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r1_ff[s+1]   <= diff1[UW-1:0];
            r2_ff[s+1]   <= diff2[UW-1:0];
            d_ff[s+1]    <= src_d;
            q1_ff[s+1]   <= {src_q1[NS-2:0], bit1};
            q2_ff[s+1]   <= {src_q2[NS-2:0], bit2};
            side_ff[s+1] <= src_side;
         end
      end
   end

   assign out_valid = v_ff[NS];
   assign q1        = q1_ff[NS];
   assign q2        = q2_ff[NS];
   assign side_out  = side_ff[NS];

endmodule

FILE: rtl/core/sgi_back.sv
// Back stages: parameter rounding and range test, point multiply, add and saturate.
module sgi_back #(
   parameter int COORD_W = sgi_pkg::COORD_W_DEF,
   parameter int T_FRAC  = sgi_pkg::T_FRAC_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [T_FRAC+2:0]                q1,
   input  logic [T_FRAC+2:0]                q2,
   input  logic                             nz,
   input  logic                             ok1,
   input  logic                             ok2,
   input  logic signed [COORD_W-1:0]        x1,
   input  logic signed [COORD_W-1:0]        y1,
   input  logic signed [COORD_W:0]          dx1,
   input  logic signed [COORD_W:0]          dy1,
   output logic                             out_valid,
   output logic                             hit,
   output logic [sgi_pkg::OUT_W-1:0]        cross_x,
   output logic [sgi_pkg::OUT_W-1:0]        cross_y
);

   localparam int QW  = T_FRAC + 3;
   localparam int TW  = T_FRAC + 2;
   localparam int MW  = T_FRAC + COORD_W + 3;
   localparam int SW  = T_FRAC + COORD_W + 4;
   localparam int XW  = (SW > sgi_pkg::OUT_W) ? SW : sgi_pkg::OUT_W + 1;
   localparam logic [QW-1:0] T_ONE = QW'(1) << T_FRAC;
   localparam logic [QW-1:0] T_TWO = QW'(1) << (T_FRAC + 1);
   localparam logic signed [XW-1:0] S_MAX = XW'(signed'(32'sh7FFF_FFFF));
   localparam logic signed [XW-1:0] S_MIN = XW'(signed'(32'sh8000_0000));

   logic [2:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   // Stage 1: round half up by one extra quotient bit. The quotient carries
   // a bias of one, so the parameter is h - 2^T and lies in [0,1] exactly
   // when h lies in [2^T, 2^(T+1)].
   logic [QW:0]   u1, u2;
   logic [QW-1:0] h1, h2, tsub;
   logic          hit_in;

   always_comb begin
      u1     = {1'b0, q1} + (QW+1)'(1);
      u2     = {1'b0, q2} + (QW+1)'(1);
      h1     = u1[QW:1];
      h2     = u2[QW:1];
      tsub   = h1 - T_ONE;
      hit_in = nz && ok1 && ok2 && (h1 >= T_ONE) && (h1 <= T_TWO)
               && (h2 >= T_ONE) && (h2 <= T_TWO);
   end

   logic                      hit1_ff, hit2_ff, hit3_ff;
   logic signed [TW-1:0]      t1_ff;
   logic signed [COORD_W-1:0] x1_b1_ff, y1_b1_ff, x1_b2_ff, y1_b2_ff;
   logic signed [COORD_W:0]   dx1_ff, dy1_ff;
   logic signed [MW-1:0]      mx_ff, my_ff;
   logic [sgi_pkg::OUT_W-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hit1_ff  <= hit_in;
         t1_ff    <= signed'(tsub[TW-1:0]);
         x1_b1_ff <= x1;
         y1_b1_ff <= y1;
         dx1_ff   <= dx1;
         dy1_ff   <= dy1;
      end
   end

   // Stage 2: scale the direction by the parameter.
   always_ff @(posedge clock) begin
      if (en) begin
         hit2_ff  <= hit1_ff;
         mx_ff    <= MW'(t1_ff) * MW'(dx1_ff);
         my_ff    <= MW'(t1_ff) * MW'(dy1_ff);
         x1_b2_ff <= x1_b1_ff;
         y1_b2_ff <= y1_b1_ff;
      end
   end

   // Stage 3: add the start point and clamp to the output range.
   logic signed [SW-1:0]      sx, sy;
   logic signed [XW-1:0]      ex, ey;
   logic [sgi_pkg::OUT_W-1:0] cx_in, cy_in;

   always_comb begin
      sx = (SW'(x1_b2_ff) <<< T_FRAC) + SW'(mx_ff);
      sy = (SW'(y1_b2_ff) <<< T_FRAC) + SW'(my_ff);
      ex = XW'(sx);
      ey = XW'(sy);
      if (!hit2_ff) begin
         cx_in = '0;
      end else if (ex > S_MAX) begin
         cx_in = S_MAX[sgi_pkg::OUT_W-1:0];
      end else if (ex < S_MIN) begin
         cx_in = S_MIN[sgi_pkg::OUT_W-1:0];
      end else begin
         cx_in = ex[sgi_pkg::OUT_W-1:0];
      end
      if (!hit2_ff) begin
         cy_in = '0;
      end else if (ey > S_MAX) begin
         cy_in = S_MAX[sgi_pkg::OUT_W-1:0];
      end else if (ey < S_MIN) begin
         cy_in = S_MIN[sgi_pkg::OUT_W-1:0];
      end else begin
         cy_in = ey[sgi_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit3_ff <= hit2_ff;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
      end
   end

   assign out_valid = v_ff[2];
   assign hit       = hit3_ff;
   assign cross_x   = cx_ff;
   assign cross_y   = cy_ff;

endmodule

FILE: rtl/core/segment_intersection.sv
// Throughput: one request per cycle while the pipeline is not held.
// Four front stages, T_FRAC + 3 divider stages (one quotient bit each), three back
// stages and an output register. The whole pipeline holds while its last stage and
// the output register are both full and rsp_tready is low.
// Reset is synchronous and active high; it clears all valid bits, payload is not reset.
module segment_intersection #(
   parameter int COORD_W = sgi_pkg::COORD_W_DEF,
   parameter int T_FRAC  = sgi_pkg::T_FRAC_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
   // b_start_x, b_start_y, b_end_x, b_end_y.
   input  logic [sgi_pkg::N_COORDS*COORD_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // Fields from bit 0 up: cross_x, cross_y.
   output logic [2*sgi_pkg::OUT_W-1:0]            rsp_tdata,
   // Fields from bit 0 up: hit.
   output logic                                   rsp_tuser
);

   localparam int UW     = 2 * COORD_W + 3;
   localparam int NS     = T_FRAC + 3;
   localparam int SIDE_W = 3 + 2 * COORD_W + 2 * (COORD_W + 1);

   logic en;
   logic f_valid, f_nz, f_ok1, f_ok2;
   logic [UW-1:0] f_n1, f_n2, f_den;
   logic signed [COORD_W-1:0] f_x1, f_y1, d_x1, d_y1;
   logic signed [COORD_W:0]   f_dx1, f_dy1, d_dx1, d_dy1;
   logic [SIDE_W-1:0] side_in, side_out;
   logic d_valid, d_nz, d_ok1, d_ok2;
   logic [NS-1:0] d_q1, d_q2;
   logic b_valid, b_hit;
   logic [sgi_pkg::OUT_W-1:0] b_cx, b_cy;

   logic rsp_valid_ff, rsp_hit_ff;
   logic [2*sgi_pkg::OUT_W-1:0] rsp_data_ff;

   // The pipeline moves unless a finished result would have nowhere to go.
   assign en         = !b_valid || !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   sgi_front #(.COORD_W(COORD_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid && en),
      .coords    (req_tdata),
      .out_valid (f_valid),
      .nz        (f_nz),
      .ok1       (f_ok1),
      .ok2       (f_ok2),
      .n1u       (f_n1),
      .n2u       (f_n2),
      .den       (f_den),
      .x1        (f_x1),
      .y1        (f_y1),
      .dx1       (f_dx1),
      .dy1       (f_dy1)
   );

   assign side_in = {f_nz, f_ok1, f_ok2, f_x1, f_y1, f_dx1, f_dy1};

   sgi_div #(.UW(UW), .NS(NS), .SIDE_W(SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .n1        (f_n1),
      .n2        (f_n2),
      .den       (f_den),
      .side_in   (side_in),
      .out_valid (d_valid),
      .q1        (d_q1),
      .q2        (d_q2),
      .side_out  (side_out)
   );

   assign {d_nz, d_ok1, d_ok2, d_x1, d_y1, d_dx1, d_dy1} = side_out;

   sgi_back #(.COORD_W(COORD_W), .T_FRAC(T_FRAC)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .q1        (d_q1),
      .q2        (d_q2),
      .nz        (d_nz),
      .ok1       (d_ok1),
      .ok2       (d_ok2),
      .x1        (d_x1),
      .y1        (d_y1),
      .dx1       (d_dx1),
      .dy1       (d_dy1),
      .out_valid (b_valid),
      .hit       (b_hit),
      .cross_x   (b_cx),
      .cross_y   (b_cy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && b_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && b_valid) begin
         rsp_hit_ff  <= b_hit;
         rsp_data_ff <= {b_cy, b_cx};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

`ifndef NO_ASSERTIONS
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("miss response carries a nonzero point");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while the output register is empty");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (!req_tready) |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without a blocked response");
`endif

endmodule

FILE: bench/segment_intersection_checker.sv
// Checker that predicts segment intersection results and compares them with the response stream.
`timescale 1ns / 1ps

module segment_intersection_checker #(
   parameter int COORD_W = sgi_pkg::COORD_W_DEF,
   parameter int T_FRAC  = sgi_pkg::T_FRAC_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [sgi_pkg::N_COORDS*COORD_W-1:0] req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [2*sgi_pkg::OUT_W-1:0]          rsp_tdata,
   input  logic                                 rsp_tuser,
   output int                                   error_count,
   output int                                   pending_count
);

   localparam int OUT_W    = sgi_pkg::OUT_W;
   localparam int N_COORDS = sgi_pkg::N_COORDS;

   typedef struct packed {
      logic             hit;
      logic [OUT_W-1:0] cross_x;
      logic [OUT_W-1:0] cross_y;
   } crossing_type;

   crossing_type crossing_q[$];

   function automatic longint coord_at(input logic [N_COORDS*COORD_W-1:0] data,
                                       input int idx);
      logic signed [COORD_W-1:0] c;
      c = data[idx*COORD_W +: COORD_W];
      return longint'(c);
   endfunction

   // Rounds num/den to nearest at T_FRAC bits, ties up; returns 0 if outside [0,1].
   function automatic bit unit_param(input longint num, input longint den, output longint t);
      longint q, r, fr, g;
      t = 0;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num < -den || num > 2 * den) return 0;
      q = num / den;
      r = num % den;
      if (r < 0) begin
         q -= 1;
         r += den;
      end
      fr = 0;
      for (int i = 0; i < T_FRAC + 1; i++) begin
         fr = fr << 1;
         r = r << 1;
         if (r >= den) begin
            r -= den;
            fr |= 1;
         end
      end
      g = q * (longint'(1) << (T_FRAC + 1)) + fr + 1 + (longint'(1) << (T_FRAC + 2));
      g = (g >>> 1) - (longint'(1) << (T_FRAC + 1));
      t = g;
      return g >= 0 && g <= (longint'(1) << T_FRAC);
   endfunction

   function automatic logic [OUT_W-1:0] clamp32(input longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[OUT_W-1:0];
   endfunction

   function automatic crossing_type predict_crossing(
      input logic [N_COORDS*COORD_W-1:0] data);
      longint x1, y1, dx1, dy1, x2, y2, dx2, dy2, den, ex, ey, t1, t2;
      crossing_type res;
      res = '0;
      x1  = coord_at(data, sgi_pkg::A_START_X);
      y1  = coord_at(data, sgi_pkg::A_START_Y);
      dx1 = coord_at(data, sgi_pkg::A_END_X) - x1;
      dy1 = coord_at(data, sgi_pkg::A_END_Y) - y1;
      x2  = coord_at(data, sgi_pkg::B_START_X);
      y2  = coord_at(data, sgi_pkg::B_START_Y);
      dx2 = coord_at(data, sgi_pkg::B_END_X) - x2;
      dy2 = coord_at(data, sgi_pkg::B_END_Y) - y2;
      den = dx2 * dy1 - dx1 * dy2;
      ex  = x2 - x1;
      ey  = y2 - y1;
      if (den == 0) return res;
      if (!unit_param(-(dy2 * ex - dx2 * ey), den, t1)) return res;
      if (!unit_param(-(dy1 * ex - dx1 * ey), den, t2)) return res;
      res.hit = 1'b1;
      res.cross_x = clamp32(x1 * (longint'(1) << T_FRAC) + t1 * dx1);
      res.cross_y = clamp32(y1 * (longint'(1) << T_FRAC) + t1 * dy1);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                  input logic [OUT_W-1:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      crossing_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) crossing_q.push_back(predict_crossing(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (crossing_q.size() == 0) begin
               report_mismatch("pending requests", '0, OUT_W'(1));
            end else begin
               want = crossing_q.pop_front();
               if (rsp_tuser !== want.hit)
                  report_mismatch("hit", OUT_W'(rsp_tuser), OUT_W'(want.hit));
               if (rsp_tdata[OUT_W-1:0] !== want.cross_x)
                  report_mismatch("cross_x", rsp_tdata[OUT_W-1:0], want.cross_x);
               if (rsp_tdata[2*OUT_W-1:OUT_W] !== want.cross_y)
                  report_mismatch("cross_y", rsp_tdata[2*OUT_W-1:OUT_W], want.cross_y);
            end
         end
      end
      pending_count = crossing_q.size();
   end

endmodule

FILE: bench/testbench.sv
// Top of the segment intersection bench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int COORD_W = sgi_pkg::COORD_W_DEF;
   localparam int T_FRAC  = sgi_pkg::T_FRAC_DEF;
   localparam int OUT_W   = sgi_pkg::OUT_W;
   localparam int N_COORDS = sgi_pkg::N_COORDS;
   localparam int LATENCY = T_FRAC + 11;
   localparam int CYCLE_LIMIT = 200000;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [N_COORDS*COORD_W-1:0]   req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [2*OUT_W-1:0]            rsp_tdata;
   logic                          rsp_tuser;
   int                            error_count;
   int                            pending_count;
   int                            cycle_count;
   bit                            steady;

   segment_intersection #(.COORD_W(COORD_W), .T_FRAC(T_FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   segment_intersection_checker #(.COORD_W(COORD_W), .T_FRAC(T_FRAC)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL segment_intersection");
            $finish;
         end
      end
   end

   // The response side stalls at random except during the steady stretch.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(99) >= 28);
   end

   function automatic logic [N_COORDS*COORD_W-1:0] pack_segments(
      input int ax0, input int ay0, input int ax1, input int ay1,
      input int bx0, input int by0, input int bx1, input int by1);
      logic [N_COORDS*COORD_W-1:0] d;
      d[sgi_pkg::A_START_X*COORD_W +: COORD_W] = ax0[COORD_W-1:0];
      d[sgi_pkg::A_START_Y*COORD_W +: COORD_W] = ay0[COORD_W-1:0];
      d[sgi_pkg::A_END_X*COORD_W +: COORD_W]   = ax1[COORD_W-1:0];
      d[sgi_pkg::A_END_Y*COORD_W +: COORD_W]   = ay1[COORD_W-1:0];
      d[sgi_pkg::B_START_X*COORD_W +: COORD_W] = bx0[COORD_W-1:0];
      d[sgi_pkg::B_START_Y*COORD_W +: COORD_W] = by0[COORD_W-1:0];
      d[sgi_pkg::B_END_X*COORD_W +: COORD_W]   = bx1[COORD_W-1:0];
      d[sgi_pkg::B_END_Y*COORD_W +: COORD_W]   = by1[COORD_W-1:0];
      return d;
   endfunction

   function automatic int rand_coord(input int span);
      if (span == 0) return $urandom_range(65535) - 32768;
      return $urandom_range(2 * span) - span;
   endfunction

   // Random pair; most are crossing-prone: b is built around a point on a.
   function automatic logic [N_COORDS*COORD_W-1:0] random_segments();
      int span, ax0, ay0, ax1, ay1, px, py;
      span = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1) == 0) ? 40 : 8000);
      ax0 = rand_coord(span);
      ay0 = rand_coord(span);
      ax1 = rand_coord(span);
      ay1 = rand_coord(span);
      if ($urandom_range(4) == 0)
         return pack_segments(ax0, ay0, ax1, ay1, rand_coord(span), rand_coord(span),
                              rand_coord(span), rand_coord(span));
      px = ax0 + (ax1 - ax0) / 2;
      py = ay0 + (ay1 - ay0) / 2;
      if ($urandom_range(9) == 0)
         return pack_segments(ax0, ay0, ax1, ay1, px, py, px + ax1 - ax0, py + ay1 - ay0);
      return pack_segments(ax0, ay0, ax1, ay1, px + rand_coord(60), py + rand_coord(60),
                           px - rand_coord(60), py - rand_coord(60));
   endfunction

   task automatic send_request(input logic [N_COORDS*COORD_W-1:0] data);
      while (!steady && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [N_COORDS*COORD_W-1:0] directed[$];
      int drain;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      steady     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Crossing, parallel, collinear overlap, endpoint touches, degenerate and extremes.
      directed.push_back(pack_segments(0, 0, 10, 10, 0, 10, 10, 0));
      directed.push_back(pack_segments(0, 0, 10, 0, 0, 5, 10, 5));
      directed.push_back(pack_segments(0, 0, 10, 0, 5, 0, 15, 0));
      directed.push_back(pack_segments(0, 0, 10, 0, 10, -5, 10, 5));
      directed.push_back(pack_segments(0, 0, 10, 0, 0, 0, 0, 7));
      directed.push_back(pack_segments(0, 0, 10, 0, 11, -5, 11, 5));
      directed.push_back(pack_segments(0, 0, 0, 0, 1, 1, 2, 2));
      directed.push_back(pack_segments(-32768, -32768, 32767, 32767,
                                       -32768, 32767, 32767, -32768));
      directed.push_back(pack_segments(32767, 32767, -32768, -32768,
                                       32767, -32768, -32768, 32767));
      directed.push_back(pack_segments(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
      // Further cases, several with a parameter at an end of [0,1].
      directed.push_back(pack_segments(0, 0, 3, 0, 3, -1, 3, 1));
      directed.push_back(pack_segments(0, 0, 65535, 0, -1, -1, -1, 1));
      directed.push_back(pack_segments(0, 0, 65535, 0, 65536, -1, 65536, 1));
      directed.push_back(pack_segments(0, 0, 3, 1, 0, 1, 3, 0));
      directed.push_back(pack_segments(-32768, -32768, -32768, 32767, -32767, 0, -32768, 0));
      directed.push_back(pack_segments(-1, -1, -1, -1, -1, -1, -1, -1));
      directed.push_back(pack_segments(5, 7, -9, 3, -20, 10, 20, 0));
      foreach (directed[i]) send_request(directed[i]);

      for (int n = 0; n < 850; n++) begin
         steady = (n >= 300 && n < 420);
         send_request(random_segments());
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      drain = 0;
      while (drain < LATENCY + 10) begin
         @(posedge clock);
         drain++;
      end
      if (error_count == 0) begin
         $display("PASS segment_intersection");
      end else begin
         $display("FAIL segment_intersection");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/sgi_pkg.sv
rtl/core/sgi_front.sv
rtl/core/sgi_div.sv
rtl/core/sgi_back.sv
rtl/core/segment_intersection.sv
bench/segment_intersection_checker.sv
bench/testbench.sv
